// ----- design/rhc_pkg.sv -----
// Shared types and constants for the RGB to HSL converter.
// Used by rhc_front, rhc_div_step and rgb_to_hsl_converter_top; depends on nothing.
package rhc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COMP_W = 8;     // one color component
   localparam int SUM_W  = 9;     // max + min
   localparam int DEN_W  = 9;     // saturation divisor, at most 256
   localparam int HUE_W  = 11;    // six times the spread, at most 1530
   localparam int DIFF_W = 9;     // signed difference of two components
   localparam int NUM_W  = 12;    // signed hue numerator before wrapping
   localparam int OUT_W  = 16;    // result fields

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Remainders, divisors and side data that travel down the divider chain.
   typedef struct packed {
      logic               grey;
      logic               sat_ovf;
      logic [DEN_W-1:0]   rem_sat;
      logic [DEN_W-1:0]   den_sat;
      logic [HUE_W-1:0]   rem_hue;
      logic [HUE_W-1:0]   den_hue;
      logic [OUT_W-1:0]   light;
   } div_type;

endpackage

// ----- design/rgb_to_hsl_converter_top.sv -----
// Throughput: one pixel per cycle while req_stall is low; two front stages, then one stage per quotient bit.
// A two-word output buffer lets the pipeline advance while a result waits;
// req_stall rises only when both buffer words are full.
// Reset (synchronous) clears every valid bit; data registers are not reset.
// Depends on rhc_pkg, rhc_front and rhc_div_step.
module rgb_to_hsl_converter_top #(
   parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rhc_pkg::COMP_W-1:0]  req_red,
   input  logic [rhc_pkg::COMP_W-1:0]  req_green,
   input  logic [rhc_pkg::COMP_W-1:0]  req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rhc_pkg::OUT_W-1:0]   rsp_hue,
   output logic [rhc_pkg::OUT_W-1:0]   rsp_saturation,
   output logic [rhc_pkg::OUT_W-1:0]   rsp_lightness
);

   logic                   advance;
   logic                   chain_valid [0:FRAC_BITS];
   rhc_pkg::div_type       chain_div   [0:FRAC_BITS];
   logic [FRAC_BITS-1:0]   chain_q_sat [0:FRAC_BITS];
   logic [FRAC_BITS-1:0]   chain_q_hue [0:FRAC_BITS];

   logic                         emit;
   logic [rhc_pkg::OUT_W-1:0]    hue_fmt, sat_fmt;

   logic                         rsp_valid_ff;
   logic [rhc_pkg::OUT_W-1:0]    rsp_hue_ff, rsp_sat_ff, rsp_light_ff;
   logic                         skid_valid_ff;
   logic [rhc_pkg::OUT_W-1:0]    skid_hue_ff, skid_sat_ff, skid_light_ff;

   // The whole pipeline moves together while the skid word is empty.
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   rhc_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (chain_valid[0]),
      .out_div   (chain_div[0])
   );

   assign chain_q_sat[0] = '0;
   assign chain_q_hue[0] = '0;

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
      rhc_div_step #(
         .FRAC_BITS (FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (chain_valid[i]),
         .in_div    (chain_div[i]),
         .in_q_sat  (chain_q_sat[i]),
         .in_q_hue  (chain_q_hue[i]),
         .out_valid (chain_valid[i+1]),
         .out_div   (chain_div[i+1]),
         .out_q_sat (chain_q_sat[i+1]),
         .out_q_hue (chain_q_hue[i+1])
      );
   end

   // Grey pixels give zero hue and saturation; a quotient of one saturates.
   always_comb begin
      logic [FRAC_BITS-1:0] sat_q;
      sat_q = chain_div[FRAC_BITS].sat_ovf ? {FRAC_BITS{1'b1}} : chain_q_sat[FRAC_BITS];
      if (chain_div[FRAC_BITS].grey) begin
         hue_fmt = '0;
         sat_fmt = '0;
      end else begin
         hue_fmt = rhc_pkg::OUT_W'(chain_q_hue[FRAC_BITS]);
         sat_fmt = rhc_pkg::OUT_W'(sat_q);
      end
   end

   assign emit = advance && chain_valid[FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= emit;
         end
      end else if (emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_hue_ff   <= skid_hue_ff;
            rsp_sat_ff   <= skid_sat_ff;
            rsp_light_ff <= skid_light_ff;
         end else if (emit) begin
            rsp_hue_ff   <= hue_fmt;
            rsp_sat_ff   <= sat_fmt;
            rsp_light_ff <= chain_div[FRAC_BITS].light;
         end
      end else if (emit) begin
         skid_hue_ff   <= hue_fmt;
         skid_sat_ff   <= sat_fmt;
         skid_light_ff <= chain_div[FRAC_BITS].light;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_lightness  = rsp_light_ff;

endmodule

// ----- design/rhc_front.sv -----
// Front end of the converter: max/min search and sector pick, then divisor,
// numerator and lightness setup. Two register stages; depends on rhc_pkg.
module rhc_front #(
   parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [rhc_pkg::COMP_W-1:0]  in_red,
   input  logic [rhc_pkg::COMP_W-1:0]  in_green,
   input  logic [rhc_pkg::COMP_W-1:0]  in_blue,
   output logic                        out_valid,
   output rhc_pkg::div_type            out_div
);

   localparam int WIDE_W = rhc_pkg::SUM_W + FRAC_BITS;

   // Stage A registers.
   logic                          a_valid_ff;
   logic [rhc_pkg::COMP_W-1:0]    a_hi_ff, a_hi_in;
   logic [rhc_pkg::COMP_W-1:0]    a_lo_ff, a_lo_in;
   rhc_pkg::sector_type           a_sector_ff, a_sector_in;
   logic [rhc_pkg::DIFF_W-1:0]    a_diff_ff, a_diff_in;

   // Stage B registers.
   logic                          b_valid_ff;
   rhc_pkg::div_type              b_div_ff, b_div_in;

   // Stage A: largest and smallest component, sector and its component difference.
   always_comb begin
      logic [rhc_pkg::COMP_W-1:0] hi;
      logic [rhc_pkg::COMP_W-1:0] lo;
      hi = in_red;
      lo = in_red;
      if (in_green > hi) hi = in_green;
      if (in_blue > hi) hi = in_blue;
      if (in_green < lo) lo = in_green;
      if (in_blue < lo) lo = in_blue;
      a_hi_in = hi;
      a_lo_in = lo;
      // Blue outranks green, which outranks red, when components tie.
      if (in_blue == hi) begin
         a_sector_in = rhc_pkg::SECTOR_BLUE;
         a_diff_in   = {1'b0, in_red} - {1'b0, in_green};
      end else if (in_green == hi) begin
         a_sector_in = rhc_pkg::SECTOR_GREEN;
         a_diff_in   = {1'b0, in_blue} - {1'b0, in_red};
      end else begin
         a_sector_in = rhc_pkg::SECTOR_RED;
         a_diff_in   = {1'b0, in_green} - {1'b0, in_blue};
      end
   end

   // Stage B: spread, divisors, numerators and lightness.
   always_comb begin
      logic [rhc_pkg::COMP_W-1:0] spread;
      logic [rhc_pkg::SUM_W-1:0]  sum;
      logic [rhc_pkg::DEN_W-1:0]  den;
      logic [rhc_pkg::DEN_W-1:0]  spread9;
      logic [rhc_pkg::HUE_W-1:0]  six_d;
      logic [rhc_pkg::HUE_W-1:0]  base;
      logic [rhc_pkg::NUM_W-1:0]  num;
      logic [WIDE_W-1:0]          wide;
      logic [FRAC_BITS-1:0]       light_f;
      spread  = a_hi_ff - a_lo_ff;
      sum     = {1'b0, a_hi_ff} + {1'b0, a_lo_ff};
      den     = sum[rhc_pkg::SUM_W-1] ?
                rhc_pkg::DEN_W'(10'd512 - {1'b0, sum}) : sum;
      spread9 = {1'b0, spread};
      six_d   = rhc_pkg::HUE_W'({spread, 2'b00}) + rhc_pkg::HUE_W'({spread, 1'b0});
      case (a_sector_ff)
         rhc_pkg::SECTOR_BLUE:  base = rhc_pkg::HUE_W'({spread, 2'b00});
         rhc_pkg::SECTOR_GREEN: base = rhc_pkg::HUE_W'({spread, 1'b0});
         default:               base = '0;
      endcase
      num = {1'b0, base}
            + {{(rhc_pkg::NUM_W - rhc_pkg::DIFF_W){a_diff_ff[rhc_pkg::DIFF_W-1]}}, a_diff_ff};
      // A negative red-sector hue wraps by one full turn.
      if (num[rhc_pkg::NUM_W-1]) begin
         num = num + {1'b0, six_d};
      end
      wide    = {sum, {FRAC_BITS{1'b0}}};
      light_f = wide[WIDE_W-1:rhc_pkg::SUM_W];

      b_div_in.grey    = (spread == '0);
      // The saturation quotient reaches one only when spread equals the divisor.
      b_div_in.sat_ovf = (spread9 >= den);
      b_div_in.rem_sat = (spread9 >= den) ? (spread9 - den) : spread9;
      b_div_in.den_sat = den;
      b_div_in.rem_hue = num[rhc_pkg::HUE_W-1:0];
      b_div_in.den_hue = six_d;
      b_div_in.light   = rhc_pkg::OUT_W'(light_f);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_hi_ff     <= a_hi_in;
         a_lo_ff     <= a_lo_in;
         a_sector_ff <= a_sector_in;
         a_diff_ff   <= a_diff_in;
         b_div_ff    <= b_div_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_div   = b_div_ff;

endmodule

// ----- design/rhc_div_step.sv -----
// One registered step of the two restoring fraction dividers (saturation and hue).
// Depends on rhc_pkg; chained FRAC_BITS deep by the top level.
module rhc_div_step #(
   parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  rhc_pkg::div_type      in_div,
   input  logic [FRAC_BITS-1:0]  in_q_sat,
   input  logic [FRAC_BITS-1:0]  in_q_hue,
   output logic                  out_valid,
   output rhc_pkg::div_type      out_div,
   output logic [FRAC_BITS-1:0]  out_q_sat,
   output logic [FRAC_BITS-1:0]  out_q_hue
);

   logic                   valid_ff;
   rhc_pkg::div_type       div_ff, div_in;
   logic [FRAC_BITS-1:0]   q_sat_ff, q_sat_in;
   logic [FRAC_BITS-1:0]   q_hue_ff, q_hue_in;

   always_comb begin
      logic [rhc_pkg::DEN_W:0] rs2;
      logic [rhc_pkg::HUE_W:0] rh2;
      logic                    bit_sat;
      logic                    bit_hue;
      rs2     = {in_div.rem_sat, 1'b0};
      rh2     = {in_div.rem_hue, 1'b0};
      bit_sat = (rs2 >= {1'b0, in_div.den_sat});
      bit_hue = (rh2 >= {1'b0, in_div.den_hue});
      div_in         = in_div;
      // The remainder stays below its divisor, so it fits back in its field.
      div_in.rem_sat = bit_sat ? rhc_pkg::DEN_W'(rs2 - {1'b0, in_div.den_sat})
                               : rhc_pkg::DEN_W'(rs2);
      div_in.rem_hue = bit_hue ? rhc_pkg::HUE_W'(rh2 - {1'b0, in_div.den_hue})
                               : rhc_pkg::HUE_W'(rh2);
      q_sat_in = {in_q_sat[FRAC_BITS-2:0], bit_sat};
      q_hue_in = {in_q_hue[FRAC_BITS-2:0], bit_hue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_ff   <= div_in;
         q_sat_ff <= q_sat_in;
         q_hue_ff <= q_hue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_q_sat = q_sat_ff;
   assign out_q_hue = q_hue_ff;

endmodule
